FILE: hw/rtl/dual_channel_light_effect_sequencer_core_defines.svh
// Assertion macros for the light effect sequencer core.
// No dependencies; included by the top level.
`ifndef DUAL_CHANNEL_LIGHT_EFFECT_SEQUENCER_CORE_DEFINES_SVH
`define DUAL_CHANNEL_LIGHT_EFFECT_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define DCLES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define DCLES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dcles_pkg.sv
// Shared types, constants and the brightness table for the light effect sequencer.
// No dependencies.
package dcles_pkg;

    typedef enum logic [1:0]
    {
        REQ_TICK   = 2'd0,
        REQ_NEXT   = 2'd1,
        REQ_TOGGLE = 2'd2,
        REQ_RANDOM = 2'd3
    } req_t;

    localparam logic [6:0] FX_STEADY    = 7'd0;
    localparam logic [6:0] FX_SYNC_SLOW = 7'd1;
    localparam logic [6:0] FX_ANTI_SLOW = 7'd2;
    localparam logic [6:0] FX_WAVE      = 7'd3;
    localparam logic [6:0] FX_SYNC_FAST = 7'd4;
    localparam logic [6:0] FX_ANTI_FAST = 7'd5;
    localparam logic [6:0] FX_SERIAL    = 7'd6;

    localparam logic [7:0] BRIGHT_MAX    = 8'd15;
    localparam logic [7:0] BRIGHT_MIN    = 8'd230;
    localparam logic [7:0] PERIOD_NORMAL = 8'd100;
    localparam logic [7:0] PERIOD_FAST   = 8'd25;
    localparam logic [7:0] PERIOD_WAVE   = 8'd200;
    localparam logic [7:0] MODE_RESET    = 8'd2;
    localparam logic [7:0] LEVEL_RESET   = 8'd1;
    localparam logic [7:0] LEVEL_TOP     = 8'd15;

    typedef struct packed
    {
        logic [7:0] mode;
        logic [7:0] level;
        logic       down;
        logic       second;
        logic [7:0] period;
    } seq_state_t;

    typedef struct packed
    {
        logic       random_on;
        logic [6:0] effect_now;
        logic [7:0] tick_period;
        logic       level_written;
        logic [7:0] level_b;
        logic [7:0] level_a;
    } seq_result_t;

    function automatic logic [7:0] bright(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'd15;
            4'd1:    val = 8'd60;
            4'd2:    val = 8'd80;
            4'd3:    val = 8'd100;
            4'd4:    val = 8'd110;
            4'd5:    val = 8'd120;
            4'd6:    val = 8'd130;
            4'd7:    val = 8'd140;
            4'd8:    val = 8'd150;
            4'd9:    val = 8'd160;
            4'd10:   val = 8'd170;
            4'd11:   val = 8'd180;
            4'd12:   val = 8'd190;
            4'd13:   val = 8'd200;
            4'd14:   val = 8'd210;
            default: val = 8'd230;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/dcles_effect.sv
// Combinational event update: mode handling and, on tick and next-effect requests, one effect step.
// Depends on dcles_pkg.
module dcles_effect
(
    input  dcles_pkg::req_t        req_type,
    input  logic [2:0]             random_draw,
    input  dcles_pkg::seq_state_t  cur,
    output dcles_pkg::seq_state_t  nxt,
    output dcles_pkg::seq_result_t res
);

    // Remainder by seven through a reciprocal multiply and one correction.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [15:0] prod;
        logic [5:0]  q;
        logic [7:0]  r;
        prod = {8'd0, x} * 16'd146;
        q    = prod[15:10];
        r    = x - 8'({2'b00, q} * 8'd7);
        if (r >= 8'd7)
        begin
            r = r - 8'd7;
        end
        return r[2:0];
    endfunction

    dcles_pkg::seq_state_t st;
    logic [6:0]  code;
    logic [7:0]  lvl_step;
    logic [7:0]  lvl_ser;
    logic [7:0]  lin;
    logic [7:0]  inv;
    logic        dir_set;
    logic        tick;
    logic [7:0]  a;
    logic [7:0]  b;
    logic        wr;

    assign dir_set  = cur.down | cur.second;
    assign lvl_step = dir_set  ? cur.level - 8'd1 : cur.level + 8'd1;
    assign lvl_ser  = cur.down ? cur.level - 8'd1 : cur.level + 8'd1;
    assign lin      = dcles_pkg::bright(~cur.level[3:0]);
    assign inv      = dcles_pkg::bright(cur.level[3:0]);

    always_comb
    begin
        st   = cur;
        tick = 1'b0;
        a    = 8'd0;
        b    = 8'd0;
        wr   = 1'b0;

        case (req_type)
            dcles_pkg::REQ_TICK:
            begin
                tick = 1'b1;
            end
            dcles_pkg::REQ_NEXT:
            begin
                st.mode = {cur.mode[7], 4'd0, mod7({1'b0, cur.mode[6:0]} + 8'd1)};
                tick    = 1'b1;
            end
            dcles_pkg::REQ_TOGGLE:
            begin
                st.mode[7] = ~cur.mode[7];
                a  = cur.mode[7] ? dcles_pkg::BRIGHT_MIN : dcles_pkg::BRIGHT_MAX;
                b  = cur.mode[7] ? dcles_pkg::BRIGHT_MAX : dcles_pkg::BRIGHT_MIN;
                wr = 1'b1;
            end
            default:
            begin
                if (cur.mode[7])
                begin
                    st.mode = {1'b1, 4'd0, (random_draw == 3'd7) ? 3'd0 : random_draw};
                end
            end
        endcase

        code = st.mode[6:0];
        if (tick)
        begin
            wr = 1'b1;
            unique case (code) inside
                dcles_pkg::FX_STEADY:
                begin
                    a         = dcles_pkg::BRIGHT_MAX;
                    b         = dcles_pkg::BRIGHT_MAX;
                    st.period = dcles_pkg::PERIOD_NORMAL;
                end
                dcles_pkg::FX_SYNC_SLOW, dcles_pkg::FX_SYNC_FAST,
                dcles_pkg::FX_ANTI_SLOW, dcles_pkg::FX_ANTI_FAST:
                begin
                    a = (code == dcles_pkg::FX_SYNC_SLOW || code == dcles_pkg::FX_SYNC_FAST)
                        ? lin : inv;
                    b = lin;
                    st.level = lvl_step;
                    if (lvl_step >= dcles_pkg::LEVEL_TOP)
                    begin
                        st.down   = 1'b1;
                        st.second = 1'b0;
                    end
                    if (lvl_step == 8'd0)
                    begin
                        st.down   = 1'b0;
                        st.second = 1'b0;
                    end
                    st.period = (code == dcles_pkg::FX_SYNC_SLOW ||
                                 code == dcles_pkg::FX_ANTI_SLOW)
                                ? dcles_pkg::PERIOD_NORMAL : dcles_pkg::PERIOD_FAST;
                end
                dcles_pkg::FX_WAVE:
                begin
                    a         = dir_set ? dcles_pkg::BRIGHT_MAX : dcles_pkg::BRIGHT_MIN;
                    b         = dir_set ? dcles_pkg::BRIGHT_MIN : dcles_pkg::BRIGHT_MAX;
                    st.down   = ~dir_set;
                    st.second = 1'b0;
                    st.period = dcles_pkg::PERIOD_WAVE;
                end
                dcles_pkg::FX_SERIAL:
                begin
                    a        = cur.second ? dcles_pkg::BRIGHT_MIN : lin;
                    b        = cur.second ? lin : dcles_pkg::BRIGHT_MIN;
                    st.level = lvl_ser;
                    if (lvl_ser >= dcles_pkg::LEVEL_TOP)
                    begin
                        st.down = 1'b1;
                    end
                    if (lvl_ser == 8'd0)
                    begin
                        st.down   = 1'b0;
                        st.second = ~cur.second;
                    end
                    st.period = dcles_pkg::PERIOD_NORMAL;
                end
                default:
                begin
                    wr = 1'b0;
                end
            endcase
        end
    end

    assign nxt = st;

    always_comb
    begin
        res.level_a       = wr ? a : 8'd0;
        res.level_b       = wr ? b : 8'd0;
        res.level_written = wr;
        res.tick_period   = st.period;
        res.effect_now    = st.mode[6:0];
        res.random_on     = st.mode[7];
    end

endmodule

FILE: hw/rtl/dual_channel_light_effect_sequencer_core.sv
// A word accepted on the slave side waits in the event register and then, with its result,
// loads into the result register, from which it is offered on the master side.
// Throughput: one word per cycle without back-pressure; the event register feeds the
// effect logic, whose result and new sequencer state load together into the result register.
// Reset (rst_n low, asynchronous) empties both registers and loads mode 2, ramp level 1,
// direction up, first channel, 100 ms tick; needs dcles_pkg, dcles_effect, defines header.
`include "dual_channel_light_effect_sequencer_core_defines.svh"

module dual_channel_light_effect_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Event words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] random_draw, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] level_a, [15:8] level_b, [16] level_written,
                                   // [24:17] tick_period, [31:25] effect_now,
                                   // [32] random_on, [39:33] zero
    // Power-on mode register.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    // Event register.
    logic                   ev_valid_reg;
    dcles_pkg::req_t        ev_type_reg;
    logic [2:0]             ev_draw_reg;

    // Sequencer state and result register.
    dcles_pkg::seq_state_t  state_reg;
    dcles_pkg::seq_state_t  state_next;
    dcles_pkg::seq_result_t res_reg;
    dcles_pkg::seq_result_t res_next;
    logic                   res_valid_reg;

    logic                   advance;
    logic                   accept;

    // Back-pressure on the master side holds one word in each of the two registers.
    // Move the event into the result register whenever that register is free
    // or being drained this cycle.
    assign advance  = ev_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !ev_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    dcles_effect u_effect
    (
        .req_type    (ev_type_reg),
        .random_draw (ev_draw_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            ev_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            ev_valid_reg <= 1'b0;
        end
    end

    // Payload of the event register needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_type_reg <= dcles_pkg::req_t'(s_tuser);
            ev_draw_reg <= s_tdata[2:0];
        end
    end

    // Config writes reload the mode byte at once; send them only while idle (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode   <= dcles_pkg::MODE_RESET;
            state_reg.level  <= dcles_pkg::LEVEL_RESET;
            state_reg.down   <= 1'b0;
            state_reg.second <= 1'b0;
            state_reg.period <= dcles_pkg::PERIOD_NORMAL;
        end
        else if (cfg_we)
        begin
            state_reg.mode <= cfg_wdata;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {7'd0, res_reg};

    // Levels are zero on any word that did not write them.
    `DCLES_ASSERT_NOW(a_unwritten_zero, clk, rst_n,
        res_valid_reg && !res_reg.level_written,
        res_reg.level_a == 8'd0 && res_reg.level_b == 8'd0,
        "levels not zero on an unwritten word")

    // The tick period only ever takes one of the three effect rates.
    `DCLES_ASSERT_NOW(a_period_legal, clk, rst_n, 1'b1,
        state_reg.period == dcles_pkg::PERIOD_NORMAL ||
        state_reg.period == dcles_pkg::PERIOD_FAST ||
        state_reg.period == dcles_pkg::PERIOD_WAVE,
        "tick period out of range")

    // An event moved forward always shows up as a result word.
    `DCLES_ASSERT_NEXT(a_advance_result, clk, rst_n, advance,
        res_valid_reg, "advanced event produced no result word")

    // A random change with random mode off leaves the mode byte alone.
    `DCLES_ASSERT_NEXT(a_random_off_hold, clk, rst_n,
        advance && !cfg_we && ev_type_reg == dcles_pkg::REQ_RANDOM && !state_reg.mode[7],
        $stable(state_reg.mode), "mode changed by random event while random mode off")

endmodule
